>>> hdl/c3kf_pkg.sv
`default_nettype none

package c3kf_pkg;

   localparam int MAX_WIDTH      = 512;
   localparam int MAX_HEIGHT     = 1024;
   localparam int COEF_FRAC_BITS = 8;
   localparam int NUM_TAPS       = 9;

   localparam int PIX_W       = 8;
   localparam int KSEL_W      = 4;
   localparam int WIDTH_W     = 10;
   localparam int HEIGHT_W    = 11;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 2;

   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int POS_W  = ((ADDR_W > WIDTH_W) ? ADDR_W : WIDTH_W) + 1;
   localparam int ROW_W  = HEIGHT_W;

   localparam int COEF_W = COEF_FRAC_BITS + 4;
   localparam int PART_W = PIX_W + 1 + COEF_W + 2;
   localparam int SUM_W  = PART_W + 2;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [2:0] column_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [PART_W-1:0] part_type;

   typedef struct packed {
      pix_type upper;
      pix_type lower;
   } line_pair_type;

   typedef struct packed {
      logic shift_en;
      logic calc_en;
   } cell_ctrl_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KERNEL_SELECT = 2'd0,
      CSR_FRAME_WIDTH   = 2'd1,
      CSR_FRAME_HEIGHT  = 2'd2
   } csr_index_type;

   typedef enum logic [KSEL_W-1:0] {
      KERN_EMBOSS     = 4'd0,
      KERN_BOX_BLUR   = 4'd1,
      KERN_SHARPEN    = 4'd2,
      KERN_ROBERTS    = 4'd3,
      KERN_HORIZ_EDGE = 4'd4,
      KERN_SOBEL      = 4'd5,
      KERN_LAPLACIAN  = 4'd6,
      KERN_GAUSSIAN   = 4'd7,
      KERN_HIGH_PASS  = 4'd8
   } kernel_code_type;

   localparam int ONE_I = 2 ** COEF_FRAC_BITS;
   localparam int TWO_I = 2 ** (COEF_FRAC_BITS + 1);

   localparam coef_type C_Z    = coef_type'(0);
   localparam coef_type C_P1   = coef_type'(ONE_I);
   localparam coef_type C_N1   = coef_type'(-ONE_I);
   localparam coef_type C_P2   = coef_type'(2 * ONE_I);
   localparam coef_type C_N2   = coef_type'(-2 * ONE_I);
   localparam coef_type C_P4   = coef_type'(4 * ONE_I);
   localparam coef_type C_N4   = coef_type'(-4 * ONE_I);
   localparam coef_type C_P9TH = coef_type'((TWO_I + 9) / 18);
   localparam coef_type C_N9TH = coef_type'(-((TWO_I + 9) / 18));
   localparam coef_type C_P89  = coef_type'((8 * TWO_I + 9) / 18);
   localparam coef_type C_NQTR = coef_type'(-((TWO_I + 4) / 8));
   localparam coef_type C_P84  = coef_type'((8 * TWO_I + 4) / 8);
   localparam coef_type C_G1   = coef_type'((TWO_I + 16) / 32);
   localparam coef_type C_G2   = coef_type'((2 * TWO_I + 16) / 32);
   localparam coef_type C_G4   = coef_type'((4 * TWO_I + 16) / 32);

   // tap k is row k/3, column k%3, column 2 newest
   function automatic coef_type kernel_coef(input logic [KSEL_W-1:0] ks,
                                            input logic [3:0] k);
      coef_type c [NUM_TAPS];
      unique case (ks)
         KERN_EMBOSS:
            c = '{C_N1, C_Z, C_Z, C_Z, C_Z, C_Z, C_Z, C_Z, C_P1};
         KERN_BOX_BLUR:
            c = '{C_P9TH, C_P9TH, C_P9TH, C_P9TH, C_P9TH, C_P9TH, C_P9TH, C_P9TH,
                  C_P9TH};
         KERN_SHARPEN:
            c = '{C_Z, C_NQTR, C_Z, C_NQTR, C_P84, C_NQTR, C_Z, C_NQTR, C_Z};
         KERN_ROBERTS:
            c = '{C_N1, C_Z, C_Z, C_Z, C_P1, C_Z, C_Z, C_Z, C_Z};
         KERN_HORIZ_EDGE:
            c = '{C_N1, C_N1, C_N1, C_Z, C_Z, C_Z, C_P1, C_P1, C_P1};
         KERN_SOBEL:
            c = '{C_N1, C_N2, C_N1, C_Z, C_Z, C_Z, C_P1, C_P2, C_P1};
         KERN_LAPLACIAN:
            c = '{C_Z, C_P1, C_Z, C_P1, C_N4, C_P1, C_Z, C_P1, C_Z};
         KERN_GAUSSIAN:
            c = '{C_G1, C_G2, C_G1, C_G2, C_G4, C_G2, C_G1, C_G2, C_G1};
         KERN_HIGH_PASS:
            c = '{C_N9TH, C_N9TH, C_N9TH, C_N9TH, C_P89, C_N9TH, C_N9TH, C_N9TH,
                  C_N9TH};
         default:
            c = '{C_Z, C_Z, C_Z, C_Z, C_Z, C_Z, C_Z, C_Z, C_Z};
      endcase
      if (k < 4'(NUM_TAPS)) begin
         return c[k];
      end
      return C_Z;
   endfunction

endpackage

`default_nettype wire

>>> hdl/c3kf_req_if.sv
`default_nettype none

interface c3kf_req_if import c3kf_pkg::*; ();
   logic    valid;
   logic    ready;
   pix_type pixel_in;
   logic    flush;

   modport source (output valid, output pixel_in, output flush, input ready);
   modport sink (input valid, input pixel_in, input flush, output ready);
endinterface

`default_nettype wire

>>> hdl/c3kf_rsp_if.sv
`default_nettype none

interface c3kf_rsp_if import c3kf_pkg::*; ();
   logic    valid;
   logic    ready;
   pix_type pixel_out;
   logic    frame_end;

   modport source (output valid, output pixel_out, output frame_end, input ready);
   modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

`default_nettype wire

>>> hdl/c3kf_line_store.sv
`default_nettype none

module c3kf_line_store import c3kf_pkg::*; (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output line_pair_type      rd_data,
   input  wire logic          wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire line_pair_type wr_data
);

   line_pair_type mem [MAX_WIDTH];
   line_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/c3kf_col_cell.sv
`default_nettype none

module c3kf_col_cell import c3kf_pkg::*; (
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire column_type    col_in,
   input  wire coef_type      coef_in [3],
   output column_type         col_out,
   output part_type           part_out
);

   column_type col_ff;
   part_type   part_ff;
   part_type   part_in;
   logic signed [PIX_W+COEF_W:0] prod [3];

   always_comb begin
      part_in = '0;
      for (int i = 0; i < 3; i++) begin
         prod[i] = $signed({1'b0, col_ff[i]}) * coef_in[i];
         part_in = part_in + PART_W'(prod[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift_en) begin
         col_ff <= col_in;
      end
      if (ctrl.calc_en) begin
         part_ff <= part_in;
      end
   end

   assign col_out  = col_ff;
   assign part_out = part_ff;

endmodule

`default_nettype wire

>>> hdl/conv3x3_kernel_filter_core.sv
// channel  dir  handshake     payload
// req_chan in   valid/ready   pixel_in[7:0], flush
// rsp_chan out  valid/ready   pixel_out[7:0], frame_end
// csr      in   csr_we        csr_index[1:0], csr_wdata[10:0]
//
// one item per clock sustained while rsp is ready
// stages: line store read, window column shift, per-column products, sum and clamp
// the first width+1 items of a frame give no result; a frame takes w*h+w+1 items
// synchronous reset clears pipeline valids and frame position and sets the default
// config; line stores need no clearing since border outputs never read them
// a stall on rsp backs up stage by stage; req is taken while a result waits
`default_nettype none

module conv3x3_kernel_filter_core import c3kf_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   c3kf_req_if.sink                    req_chan,
   c3kf_rsp_if.source                  rsp_chan,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [KSEL_W-1:0]   kernel_select_ff;
   logic [WIDTH_W-1:0]  frame_width_ff;
   logic [HEIGHT_W-1:0] frame_height_ff;
   logic [ADDR_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic                pos_clear;

   logic [POS_W-1:0] w_eff, c_pos, c_next, ocol;
   logic [ROW_W-1:0] h_eff, orow;
   logic             wrap, has_res, interior, last;
   logic             accept;
   pix_type          pix;

   logic b_valid_ff, b_res_ff, b_int_ff, b_last_ff;
   pix_type b_pix_ff;
   logic [ADDR_W-1:0] b_addr_ff;
   logic c_valid_ff, c_res_ff, c_int_ff, c_last_ff;
   logic d_valid_ff, d_int_ff, d_last_ff;
   logic rsp_valid_ff, rsp_last_ff;
   pix_type rsp_pix_ff, rsp_pix_in;
   logic b_adv, c_adv, d_adv;

   line_pair_type rd_pair, wr_pair;
   column_type    new_col;
   column_type    col_out [3];
   part_type      part [3];
   coef_type      coef [3][3];
   cell_ctrl_type cell_ctrl;
   logic signed [SUM_W-1:0] sum;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_select_ff <= KSEL_W'(KERN_BOX_BLUR);
         frame_width_ff   <= WIDTH_W'(512);
         frame_height_ff  <= HEIGHT_W'(512);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KERNEL_SELECT: kernel_select_ff <= csr_wdata[KSEL_W-1:0];
            CSR_FRAME_WIDTH:   frame_width_ff   <= csr_wdata[WIDTH_W-1:0];
            CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   assign pos_clear = csr_we && (csr_index == CSR_FRAME_WIDTH ||
                                 csr_index == CSR_FRAME_HEIGHT);

   // frame position
   always_comb begin
      if (frame_width_ff < WIDTH_W'(3)) begin
         w_eff = POS_W'(3);
      end else if (POS_W'(frame_width_ff) > POS_W'(MAX_WIDTH)) begin
         w_eff = POS_W'(MAX_WIDTH);
      end else begin
         w_eff = POS_W'(frame_width_ff);
      end
      if (frame_height_ff < HEIGHT_W'(3)) begin
         h_eff = ROW_W'(3);
      end else if (frame_height_ff > HEIGHT_W'(MAX_HEIGHT)) begin
         h_eff = ROW_W'(MAX_HEIGHT);
      end else begin
         h_eff = frame_height_ff;
      end

      c_pos   = (POS_W'(col_ff) >= w_eff) ? '0 : POS_W'(col_ff);
      c_next  = c_pos + POS_W'(1);
      wrap    = c_next >= w_eff;
      has_res = !(row_ff == '0 || (row_ff == ROW_W'(1) && c_pos == '0));
      if (c_pos != '0) begin
         orow = row_ff - ROW_W'(1);
         ocol = c_pos - POS_W'(1);
      end else begin
         orow = row_ff - ROW_W'(2);
         ocol = w_eff - POS_W'(1);
      end
      interior = orow >= ROW_W'(1) && orow <= h_eff - ROW_W'(2) &&
                 ocol >= POS_W'(1) && ocol <= w_eff - POS_W'(2);
      last     = has_res && orow >= h_eff - ROW_W'(1) && ocol == w_eff - POS_W'(1);

      if (last) begin
         col_in = '0;
         row_in = '0;
      end else if (wrap) begin
         col_in = '0;
         row_in = row_ff + ROW_W'(1);
      end else begin
         col_in = c_next[ADDR_W-1:0];
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || pos_clear) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // pipeline control
   assign b_adv  = b_valid_ff && (!c_valid_ff || c_adv);
   assign c_adv  = c_valid_ff && (!d_valid_ff || d_adv);
   assign d_adv  = d_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !b_valid_ff || b_adv;
   assign accept = req_chan.valid && req_chan.ready;
   assign pix    = req_chan.flush ? '0 : req_chan.pixel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            b_valid_ff <= 1'b1;
         end else if (b_adv) begin
            b_valid_ff <= 1'b0;
         end
         if (b_adv) begin
            c_valid_ff <= 1'b1;
         end else if (c_adv) begin
            c_valid_ff <= 1'b0;
         end
         if (c_adv) begin
            d_valid_ff <= c_res_ff;
         end else if (d_adv) begin
            d_valid_ff <= 1'b0;
         end
         if (d_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_pix_ff  <= pix;
         b_addr_ff <= c_pos[ADDR_W-1:0];
         b_res_ff  <= has_res;
         b_int_ff  <= interior;
         b_last_ff <= last;
      end
      if (b_adv) begin
         c_res_ff  <= b_res_ff;
         c_int_ff  <= b_int_ff;
         c_last_ff <= b_last_ff;
      end
      if (c_adv) begin
         d_int_ff  <= c_int_ff;
         d_last_ff <= c_last_ff;
      end
      if (d_adv) begin
         rsp_pix_ff  <= rsp_pix_in;
         rsp_last_ff <= d_last_ff;
      end
   end

   // line stores
   assign wr_pair.upper = rd_pair.lower;
   assign wr_pair.lower = b_pix_ff;

   c3kf_line_store u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (c_pos[ADDR_W-1:0]),
      .rd_data (rd_pair),
      .wr_en   (b_adv),
      .wr_addr (b_addr_ff),
      .wr_data (wr_pair)
   );

   // window column cells
   assign new_col[0] = rd_pair.upper;
   assign new_col[1] = rd_pair.lower;
   assign new_col[2] = b_pix_ff;

   assign cell_ctrl.shift_en = b_adv;
   assign cell_ctrl.calc_en  = c_adv;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            coef[j][i] = kernel_coef(kernel_select_ff, 4'(i * 3 + j));
         end
      end
   end

   c3kf_col_cell u_cell2 (
      .clock    (clock),
      .ctrl     (cell_ctrl),
      .col_in   (new_col),
      .coef_in  (coef[2]),
      .col_out  (col_out[2]),
      .part_out (part[2])
   );

   c3kf_col_cell u_cell1 (
      .clock    (clock),
      .ctrl     (cell_ctrl),
      .col_in   (col_out[2]),
      .coef_in  (coef[1]),
      .col_out  (col_out[1]),
      .part_out (part[1])
   );

   c3kf_col_cell u_cell0 (
      .clock    (clock),
      .ctrl     (cell_ctrl),
      .col_in   (col_out[1]),
      .coef_in  (coef[0]),
      .col_out  (col_out[0]),
      .part_out (part[0])
   );

   // sum and clamp
   always_comb begin
      sum = SUM_W'(part[0]) + SUM_W'(part[1]) + SUM_W'(part[2]);
      if (!d_int_ff || sum[SUM_W-1]) begin
         rsp_pix_in = '0;
      end else if (|sum[SUM_W-2:COEF_FRAC_BITS+PIX_W]) begin
         rsp_pix_in = '1;
      end else begin
         rsp_pix_in = sum[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pixel_out = rsp_pix_ff;
   assign rsp_chan.frame_end = rsp_last_ff;

`ifndef SYNTHESIS
   // the restart after frame end rereads column zero; only first row items see it
   a_store_no_collision: assert property (@(posedge clock) disable iff (reset)
      !(accept && b_adv && !b_last_ff && c_pos[ADDR_W-1:0] == b_addr_ff))
      else $error("line store read and write hit the same column");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      POS_W'(col_ff) < w_eff)
      else $error("column position beyond frame width");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= h_eff + ROW_W'(1))
      else $error("row position beyond frame end");

   a_last_on_border: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_last_ff |-> b_res_ff && !b_int_ff)
      else $error("frame end flagged on an interior item");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && last && !pos_clear |=> col_ff == '0 && row_ff == '0)
      else $error("frame position not restarted after frame end");
`endif

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import c3kf_pkg::*;

   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_CYCLES  = 300;
   localparam int KERNEL_COUNT  = int'(KERN_HIGH_PASS) + 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef struct packed {
      pix_type pixel;
      logic    frame_end;
   } out_pixel_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   c3kf_req_if req_chan ();
   c3kf_rsp_if rsp_chan ();

   conv3x3_kernel_filter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // filter predictor state
   pix_type               line_older [MAX_WIDTH];
   pix_type               line_newer [MAX_WIDTH];
   pix_type               win [NUM_TAPS];
   int                    col_at;
   int                    row_at;
   logic [KSEL_W-1:0]     cfg_kernel;
   logic [WIDTH_W-1:0]    cfg_width;
   logic [HEIGHT_W-1:0]   cfg_height;
   out_pixel_type         expected_pixels [$];

   int kern_weight [KERNEL_COUNT][NUM_TAPS] = '{
      '{-1,  0,  0,  0,  0,  0,  0,  0,  1},
      '{ 1,  1,  1,  1,  1,  1,  1,  1,  1},
      '{ 0, -1,  0, -1,  8, -1,  0, -1,  0},
      '{-1,  0,  0,  0,  1,  0,  0,  0,  0},
      '{-1, -1, -1,  0,  0,  0,  1,  1,  1},
      '{-1, -2, -1,  0,  0,  0,  1,  2,  1},
      '{ 0,  1,  0,  1, -4,  1,  0,  1,  0},
      '{ 1,  2,  1,  2,  4,  2,  1,  2,  1},
      '{-1, -1, -1, -1,  8, -1, -1, -1, -1}
   };
   int kern_div [KERNEL_COUNT] = '{1, 9, 4, 1, 1, 1, 1, 16, 9};

   int send_idle_pct;
   int recv_idle_pct;
   int stall_left;
   int items_sent;
   int results_seen;
   int frame_ends;
   int error_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int span_w();
      if (cfg_width < 3) return 3;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return int'(cfg_width);
   endfunction

   function automatic int span_h();
      if (cfg_height < 3) return 3;
      if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
      return int'(cfg_height);
   endfunction

   function automatic int q8_weight(input int num, input int den);
      int mag;
      int r;
      mag = (num < 0) ? -num : num;
      r = (mag * (2 << COEF_FRAC_BITS) + den) / (2 * den);
      return (num < 0) ? -r : r;
   endfunction

   function automatic pix_type filter_window();
      int acc;
      acc = 0;
      if (cfg_kernel > KERN_HIGH_PASS) return '0;
      for (int k = 0; k < NUM_TAPS; k++)
         acc += q8_weight(kern_weight[cfg_kernel][k], kern_div[cfg_kernel]) * int'(win[k]);
      if (acc < 0) return '0;
      acc = acc >>> COEF_FRAC_BITS;
      return (acc > 255) ? 8'hFF : pix_type'(acc);
   endfunction

   function automatic void advance_filter(input pix_type p, input logic f);
      int w, h, c, r, orow, ocol;
      pix_type pix, top, mid, val;
      logic last;
      w = span_w();
      h = span_h();
      c = col_at;
      r = row_at;
      pix = f ? '0 : p;
      if (c >= w) c = 0;
      top = line_older[c];
      mid = line_newer[c];
      line_older[c] = mid;
      line_newer[c] = pix;
      for (int k = 0; k < 3; k++) begin
         win[k * 3]     = win[k * 3 + 1];
         win[k * 3 + 1] = win[k * 3 + 2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = pix;
      col_at = c + 1;
      row_at = r;
      if (col_at >= w) begin
         col_at = 0;
         row_at = r + 1;
      end
      if (r == 0 || (r == 1 && c == 0)) return;
      if (c >= 1) begin
         orow = r - 1;
         ocol = c - 1;
      end else begin
         orow = r - 2;
         ocol = w - 1;
      end
      val = '0;
      if (orow >= 1 && orow <= h - 2 && ocol >= 1 && ocol <= w - 2) val = filter_window();
      last = (orow >= h - 1) && (ocol == w - 1);
      if (last) begin
         col_at = 0;
         row_at = 0;
      end
      expected_pixels.push_back('{pixel: val, frame_end: last});
   endfunction

   function automatic pix_type pick_pixel();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return pix_type'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_kernel_word();
      int k;
      k = ($urandom_range(99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 15);
      return {7'($urandom_range(127)), 4'(k)};
   endfunction

   task automatic send_pixel(input pix_type p, input logic f);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid    <= 1'b1;
      req_chan.pixel_in <= p;
      req_chan.flush    <= f;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      advance_filter(p, f);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_KERNEL_SELECT: cfg_kernel = data[KSEL_W-1:0];
         CSR_FRAME_WIDTH: begin
            cfg_width = data[WIDTH_W-1:0];
            col_at = 0;
            row_at = 0;
         end
         CSR_FRAME_HEIGHT: begin
            cfg_height = data[HEIGHT_W-1:0];
            col_at = 0;
            row_at = 0;
         end
         default: ;
      endcase
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed_frame();
      pix_type art [9];
      repeat (5) send_pixel(pick_pixel(), 1'b0);
      drain_results();
      // width and height below range act as 3
      csr_write(CSR_FRAME_WIDTH, 11'd2);
      csr_write(CSR_FRAME_HEIGHT, 11'd0);
      csr_write(CSR_KERNEL_SELECT, {7'h7F, 4'(KERN_SHARPEN)});
      csr_write(CSR_SPARE_INDEX, 11'h7FF);
      art = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
      // flush inside the frame stands for a zero pixel
      for (int i = 0; i < 9; i++)
         send_pixel(art[i], i == 3);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h00, 1'b1);
      send_pixel(8'h80, 1'b0);
      send_pixel(8'hFF, 1'b1);
      repeat (5) send_pixel(pick_pixel(), 1'b0);
      drain_results();
   endtask

   task automatic test_random_frames(input int item_goal, input int s_pct, input int r_pct);
      int sent, span, n, pick, cut_at, swap_at;
      logic [CSR_DATA_W-1:0] wdata;
      logic f;
      bit fresh;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      sent = 0;
      fresh = 1'b1;
      while (sent < item_goal) begin
         if (fresh) begin
            drain_results();
            pick = $urandom_range(99);
            if (pick < 70) wdata = CSR_DATA_W'($urandom_range(3, 10));
            else if (pick < 80) wdata = CSR_DATA_W'($urandom_range(11, 40));
            else if (pick < 90) wdata = CSR_DATA_W'($urandom_range(0, 2));
            else wdata = {1'b1, 10'($urandom_range(3, 9))};
            csr_write(CSR_FRAME_WIDTH, wdata);
            if ($urandom_range(99) < 60) begin
               if ($urandom_range(99) < 85) wdata = CSR_DATA_W'($urandom_range(3, 8));
               else wdata = CSR_DATA_W'($urandom_range(0, 2));
               csr_write(CSR_FRAME_HEIGHT, wdata);
            end
            if ($urandom_range(99) < 80) csr_write(CSR_KERNEL_SELECT, pick_kernel_word());
         end
         span = span_w() * span_h();
         n = span + span_w() + 1;
         pick = $urandom_range(99);
         cut_at = (pick < 10) ? $urandom_range(1, n - 1) : n;
         swap_at = (pick >= 10 && pick < 20) ? $urandom_range(1, n - 1) : -1;
         for (int i = 0; i < cut_at; i++) begin
            if (i == swap_at) begin
               drain_results();
               csr_write(CSR_KERNEL_SELECT, pick_kernel_word());
            end
            if (i >= span) f = 1'($urandom_range(1));
            else f = ($urandom_range(99) < 4);
            send_pixel(pick_pixel(), f);
         end
         sent += cut_at;
         fresh = (pick < 10) || ($urandom_range(99) < 65);
      end
      drain_results();
   endtask

   task automatic test_size_extremes();
      drain_results();
      // width above range acts as the line store size
      csr_write(CSR_FRAME_WIDTH, 11'd1023);
      csr_write(CSR_FRAME_HEIGHT, 11'd1024);
      csr_write(CSR_KERNEL_SELECT, CSR_DATA_W'(KERN_GAUSSIAN));
      repeat (520) send_pixel(pick_pixel(), 1'b0);
      drain_results();
      csr_write(CSR_FRAME_HEIGHT, 11'd2047);
      csr_write(CSR_FRAME_WIDTH, 11'd3);
      csr_write(CSR_KERNEL_SELECT, CSR_DATA_W'(KERN_HIGH_PASS));
      repeat (40) send_pixel(pick_pixel(), 1'b0);
      drain_results();
      csr_write(CSR_FRAME_WIDTH, 11'd512);
      csr_write(CSR_FRAME_HEIGHT, 11'd3);
      csr_write(CSR_KERNEL_SELECT, CSR_DATA_W'(KERN_BOX_BLUR));
      repeat (520) send_pixel(pick_pixel(), 1'b0);
      drain_results();
   endtask

   task automatic test_output_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      drain_results();
      csr_write(CSR_FRAME_WIDTH, 11'd16);
      csr_write(CSR_FRAME_HEIGHT, 11'd12);
      csr_write(CSR_KERNEL_SELECT, CSR_DATA_W'(KERN_SOBEL));
      for (int i = 0; i < 16 * 12 + 17; i++) begin
         if (i == 40) stall_left = STALL_CYCLES;
         send_pixel(pick_pixel(), 1'b0);
      end
      drain_results();
   endtask

   // receiver side
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_results
      out_pixel_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (rsp_chan.frame_end) frame_ends++;
         if (expected_pixels.size() == 0) begin
            error_count++;
            $display("%0t: unexpected item, expected none, got pixel_out %0d frame_end %0b",
                     $time, rsp_chan.pixel_out, rsp_chan.frame_end);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_chan.pixel_out !== want.pixel) begin
               error_count++;
               $display("%0t: pixel_out expected %0d got %0d",
                        $time, want.pixel, rsp_chan.pixel_out);
            end
            if (rsp_chan.frame_end !== want.frame_end) begin
               error_count++;
               $display("%0t: frame_end expected %0b got %0b",
                        $time, want.frame_end, rsp_chan.frame_end);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.pixel_in = '0;
      req_chan.flush    = 1'b0;
      csr_we    = 1'b0;
      csr_index = CSR_KERNEL_SELECT;
      csr_wdata = '0;
      send_idle_pct = 29;
      recv_idle_pct = 54;
      stall_left = 0;
      items_sent = 0;
      results_seen = 0;
      frame_ends = 0;
      error_count = 0;
      foreach (line_older[i]) line_older[i] = '0;
      foreach (line_newer[i]) line_newer[i] = '0;
      foreach (win[i]) win[i] = '0;
      col_at = 0;
      row_at = 0;
      cfg_kernel = KERN_BOX_BLUR;
      cfg_width  = 10'd512;
      cfg_height = 11'd512;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_frame();
      test_random_frames(100, 29, 54);
      test_size_extremes();
      test_output_stall();
      test_random_frames(100, 54, 29);
      test_random_frames(100, 0, 0);
      drain_results();

      if (expected_pixels.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected items never arrived", $time, expected_pixels.size());
      end
      $display("run covered %0d items in, %0d results checked, %0d frame ends", items_sent,
               results_seen, frame_ends);
      $display("all kernel codes, widths 3 to 512, heights 3 to 1024, out of range sizes, %0s",
               "flush padding, cut frames and a long output stall");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
